// ===== hdl/mandelbrot_escape_pixel_macros.svh =====
// Assertion macros for the checker file of the escape-time pixel block.
`ifndef MANDELBROT_ESCAPE_PIXEL_MACROS_SVH
`define MANDELBROT_ESCAPE_PIXEL_MACROS_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define MEP_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion on the block clock and reset.
`define MEP_ASSERT(lbl, prop, msg) `MEP_ASSERT_CLK(lbl, aclk, aresetn, prop, msg)

`endif

// ===== hdl/mep_pkg.sv =====
// Shared types, constants and functions of the escape-time pixel block.
`default_nettype none

package mep_pkg;

    localparam int MAX_COLUMNS    = 4096;
    localparam int MAX_ROWS       = 4096;
    localparam int ITER_LIMIT_MAX = 32768;

    localparam int COL_W   = 12;
    localparam int ROW_W   = 12;
    localparam int COUNT_W = 15;
    localparam int PIX_W   = 24;
    localparam int LIMIT_W = 16;
    localparam int WIDTH_W = 13;
    localparam int STEP_W  = 31;
    localparam int Q_W     = 32;
    localparam int Z_W     = 29;
    localparam int SQ_W    = 55;
    localparam int NZ_W    = 34;
    localparam int MAP_W   = 46;
    localparam int PROD_W  = 64;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_REAL     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_IMAG     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_REAL       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_IMAG       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ITERATION_LIMIT = 3'd5;

    localparam logic signed [Q_W-1:0] ORIGIN_REAL_RST = -32'sd98146714;
    localparam logic signed [Q_W-1:0] ORIGIN_IMAG_RST = -32'sd42467328;
    localparam logic [STEP_W-1:0]     STEP_REAL_RST   = 31'd118057;
    localparam logic [STEP_W-1:0]     STEP_IMAG_RST   = 31'd118129;
    localparam logic [WIDTH_W-1:0]    IMAGE_WIDTH_RST = 13'd1280;
    localparam logic [LIMIT_W-1:0]    ITER_LIMIT_RST  = 16'd32768;

    // Escape bound of 4.0 on each part and of 16.0 on the squared magnitude.
    localparam logic signed [NZ_W-1:0] ESC_BOUND = 34'sd134217728;
    localparam logic [SQ_W:0]          ESC_SQ    = 56'd1 << 54;

    localparam logic [7:0] SCALE5_LUT [32] = '{
        8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
        8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
        8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
        8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
    };

    typedef struct packed {
        logic signed [Q_W-1:0] origin_real;
        logic signed [Q_W-1:0] origin_imag;
        logic [STEP_W-1:0]     step_real;
        logic [STEP_W-1:0]     step_imag;
        logic [WIDTH_W-1:0]    image_width;
        logic [LIMIT_W-1:0]    iteration_limit;
    } cfg_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [PIX_W-1:0]   pixel_index;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAP_CR,
        ST_MAP_CI,
        ST_MAP_PIX,
        ST_MAP_END,
        ST_NEXT,
        ST_SQR,
        ST_SQI,
        ST_TEST,
        ST_DONE
    } core_state_t;

    function automatic logic signed [Q_W-1:0] sat_q32(input logic signed [MAP_W-1:0] v);
        logic signed [MAP_W-1:0] hi;
        logic signed [MAP_W-1:0] lo;
        hi = MAP_W'(64'sh7FFF_FFFF);
        lo = -MAP_W'(64'sh8000_0000);
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end
        return v[Q_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/mep_cfg_regs.sv =====
// Configuration register file with a plain write port.
`default_nettype none

module mep_cfg_regs (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [mep_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [31:0]                     cfg_wdata,
    output mep_pkg::cfg_t                        cfg
);

    mep_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.origin_real     <= mep_pkg::ORIGIN_REAL_RST;
            cfg_reg.origin_imag     <= mep_pkg::ORIGIN_IMAG_RST;
            cfg_reg.step_real       <= mep_pkg::STEP_REAL_RST;
            cfg_reg.step_imag       <= mep_pkg::STEP_IMAG_RST;
            cfg_reg.image_width     <= mep_pkg::IMAGE_WIDTH_RST;
            cfg_reg.iteration_limit <= mep_pkg::ITER_LIMIT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                mep_pkg::CFG_ORIGIN_REAL: begin
                    cfg_reg.origin_real <= cfg_wdata;
                end
                mep_pkg::CFG_ORIGIN_IMAG: begin
                    cfg_reg.origin_imag <= cfg_wdata;
                end
                mep_pkg::CFG_STEP_REAL: begin
                    cfg_reg.step_real <= cfg_wdata[mep_pkg::STEP_W-1:0];
                end
                mep_pkg::CFG_STEP_IMAG: begin
                    cfg_reg.step_imag <= cfg_wdata[mep_pkg::STEP_W-1:0];
                end
                mep_pkg::CFG_IMAGE_WIDTH: begin
                    cfg_reg.image_width <= cfg_wdata[mep_pkg::WIDTH_W-1:0];
                end
                mep_pkg::CFG_ITERATION_LIMIT: begin
                    cfg_reg.iteration_limit <= cfg_wdata[mep_pkg::LIMIT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== hdl/mep_mul.sv =====
// Shared signed 32 by 32 multiplier with a registered product.
`default_nettype none

module mep_mul (
    input  wire logic                                 aclk,
    input  wire logic signed [mep_pkg::Q_W-1:0]       mul_a,
    input  wire logic signed [mep_pkg::Q_W-1:0]       mul_b,
    output logic signed [mep_pkg::PROD_W-1:0]         prod
);

    logic signed [mep_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ===== hdl/mep_core.sv =====
// Sequencer and datapath that map the pixel and run the escape-time iteration.
`default_nettype none

module mep_core (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire mep_pkg::cfg_t                     cfg,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [mep_pkg::COL_W-1:0]         in_column,
    input  wire logic [mep_pkg::ROW_W-1:0]         in_row,
    output logic signed [mep_pkg::Q_W-1:0]         mul_a,
    output logic signed [mep_pkg::Q_W-1:0]         mul_b,
    input  wire logic signed [mep_pkg::PROD_W-1:0] prod,
    output logic                                   res_valid,
    input  wire logic                              res_ready,
    output mep_pkg::result_t                       res
);

    mep_pkg::core_state_t state_reg, state_next;

    logic [mep_pkg::COL_W-1:0]         col_reg, col_next;
    logic [mep_pkg::ROW_W-1:0]         row_reg, row_next;
    logic signed [mep_pkg::Q_W-1:0]    cr_reg, cr_next;
    logic signed [mep_pkg::Q_W-1:0]    ci_reg, ci_next;
    logic [mep_pkg::PIX_W-1:0]         pix_reg, pix_next;
    logic [mep_pkg::LIMIT_W-1:0]       k_reg, k_next;
    logic signed [mep_pkg::Z_W-1:0]    zr_reg, zr_next;
    logic signed [mep_pkg::Z_W-1:0]    zi_reg, zi_next;
    logic [mep_pkg::SQ_W-1:0]          sqr_reg, sqr_next;
    logic [mep_pkg::SQ_W-1:0]          sqi_reg, sqi_next;
    logic [mep_pkg::COUNT_W-1:0]       count_reg, count_next;

    logic [mep_pkg::COL_W-1:0]         col_sat;
    logic [mep_pkg::ROW_W-1:0]         row_sat;
    logic [mep_pkg::LIMIT_W-1:0]       limit;
    logic [mep_pkg::LIMIT_W-1:0]       k_inc;
    logic signed [mep_pkg::MAP_W-1:0]  map_sum_r;
    logic signed [mep_pkg::MAP_W-1:0]  map_sum_i;
    logic signed [mep_pkg::SQ_W:0]     sq_diff;
    logic signed [mep_pkg::NZ_W-1:0]   nr;
    logic signed [mep_pkg::NZ_W-1:0]   ni;
    logic                              out_of_bound;
    logic [mep_pkg::SQ_W:0]            mag_sq;

    // Indices beyond the supported image size map to the last column or row.
    assign col_sat = ({5'd0, col_reg} > 17'(mep_pkg::MAX_COLUMNS - 1))
                   ? mep_pkg::COL_W'(mep_pkg::MAX_COLUMNS - 1) : col_reg;
    assign row_sat = ({5'd0, row_reg} > 17'(mep_pkg::MAX_ROWS - 1))
                   ? mep_pkg::ROW_W'(mep_pkg::MAX_ROWS - 1) : row_reg;

    assign limit = (cfg.iteration_limit > mep_pkg::LIMIT_W'(mep_pkg::ITER_LIMIT_MAX))
                 ? mep_pkg::LIMIT_W'(mep_pkg::ITER_LIMIT_MAX) : cfg.iteration_limit;
    assign k_inc = k_reg + 16'd1;

    assign map_sum_r = {{14{cfg.origin_real[31]}}, cfg.origin_real} + prod[mep_pkg::MAP_W-1:0];
    assign map_sum_i = {{14{cfg.origin_imag[31]}}, cfg.origin_imag} + prod[mep_pkg::MAP_W-1:0];

    // The real part floors (zr^2 - zi^2) / 2^25, the imaginary part floors zr*zi / 2^24.
    assign sq_diff = $signed({1'b0, sqr_reg}) - $signed({1'b0, sqi_reg});
    assign nr = {{3{sq_diff[55]}}, sq_diff[55:25]} + {{2{cr_reg[31]}}, cr_reg};
    assign ni = {{2{prod[55]}}, prod[55:24]} + {{2{ci_reg[31]}}, ci_reg};
    assign out_of_bound = (nr > mep_pkg::ESC_BOUND) || (nr < -mep_pkg::ESC_BOUND)
                       || (ni > mep_pkg::ESC_BOUND) || (ni < -mep_pkg::ESC_BOUND);
    assign mag_sq = {1'b0, sqr_reg} + {1'b0, prod[mep_pkg::SQ_W-1:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mep_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        col_reg   <= col_next;
        row_reg   <= row_next;
        cr_reg    <= cr_next;
        ci_reg    <= ci_next;
        pix_reg   <= pix_next;
        k_reg     <= k_next;
        zr_reg    <= zr_next;
        zi_reg    <= zi_next;
        sqr_reg   <= sqr_next;
        sqi_reg   <= sqi_next;
        count_reg <= count_next;
    end

    always_comb begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        cr_next    = cr_reg;
        ci_next    = ci_reg;
        pix_next   = pix_reg;
        k_next     = k_reg;
        zr_next    = zr_reg;
        zi_next    = zi_reg;
        sqr_next   = sqr_reg;
        sqi_next   = sqi_reg;
        count_next = count_reg;
        mul_a      = '0;
        mul_b      = '0;
        in_ready   = 1'b0;
        res_valid  = 1'b0;

        unique case (state_reg)
            mep_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    col_next   = in_column;
                    row_next   = in_row;
                    state_next = mep_pkg::ST_MAP_CR;
                end
            end
            mep_pkg::ST_MAP_CR: begin
                mul_a      = $signed({20'd0, col_sat});
                mul_b      = $signed({1'b0, cfg.step_real});
                state_next = mep_pkg::ST_MAP_CI;
            end
            mep_pkg::ST_MAP_CI: begin
                cr_next    = mep_pkg::sat_q32(map_sum_r);
                mul_a      = $signed({20'd0, row_sat});
                mul_b      = $signed({1'b0, cfg.step_imag});
                state_next = mep_pkg::ST_MAP_PIX;
            end
            mep_pkg::ST_MAP_PIX: begin
                ci_next    = mep_pkg::sat_q32(map_sum_i);
                mul_a      = $signed({20'd0, row_reg});
                mul_b      = $signed({19'd0, cfg.image_width});
                state_next = mep_pkg::ST_MAP_END;
            end
            mep_pkg::ST_MAP_END: begin
                pix_next = prod[mep_pkg::PIX_W-1:0] + {12'd0, col_reg};
                zr_next  = '0;
                zi_next  = '0;
                sqr_next = '0;
                sqi_next = '0;
                k_next   = '0;
                if (limit == '0) begin
                    count_next = '0;
                    state_next = mep_pkg::ST_DONE;
                end else begin
                    state_next = mep_pkg::ST_NEXT;
                end
            end
            mep_pkg::ST_NEXT: begin
                if (out_of_bound) begin
                    count_next = k_reg[mep_pkg::COUNT_W-1:0];
                    state_next = mep_pkg::ST_DONE;
                end else begin
                    zr_next    = nr[mep_pkg::Z_W-1:0];
                    zi_next    = ni[mep_pkg::Z_W-1:0];
                    state_next = mep_pkg::ST_SQR;
                end
            end
            mep_pkg::ST_SQR: begin
                mul_a      = {{3{zr_reg[28]}}, zr_reg};
                mul_b      = {{3{zr_reg[28]}}, zr_reg};
                state_next = mep_pkg::ST_SQI;
            end
            mep_pkg::ST_SQI: begin
                sqr_next   = prod[mep_pkg::SQ_W-1:0];
                mul_a      = {{3{zi_reg[28]}}, zi_reg};
                mul_b      = {{3{zi_reg[28]}}, zi_reg};
                state_next = mep_pkg::ST_TEST;
            end
            mep_pkg::ST_TEST: begin
                sqi_next = prod[mep_pkg::SQ_W-1:0];
                mul_a    = {{3{zr_reg[28]}}, zr_reg};
                mul_b    = {{3{zi_reg[28]}}, zi_reg};
                if (mag_sq > mep_pkg::ESC_SQ) begin
                    count_next = k_reg[mep_pkg::COUNT_W-1:0];
                    state_next = mep_pkg::ST_DONE;
                end else if (k_inc == limit) begin
                    count_next = '0;
                    state_next = mep_pkg::ST_DONE;
                end else begin
                    k_next     = k_inc;
                    state_next = mep_pkg::ST_NEXT;
                end
            end
            mep_pkg::ST_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = mep_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mep_pkg::ST_IDLE;
            end
        endcase
    end

    assign res.count       = count_reg;
    assign res.pixel_index = pix_reg;

endmodule

`default_nettype wire

// ===== hdl/mep_out_stage.sv =====
// Output register that splits the count into color channels and holds the result item.
`default_nettype none

module mep_out_stage (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          res_valid,
    output logic                               res_ready,
    input  wire mep_pkg::result_t              res,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [mep_pkg::COUNT_W-1:0]        m_iteration_count,
    output logic [7:0]                         m_blue,
    output logic [7:0]                         m_green,
    output logic [7:0]                         m_red,
    output logic [mep_pkg::PIX_W-1:0]          m_pixel_index
);

    logic                          valid_reg;
    logic [mep_pkg::COUNT_W-1:0]   count_reg;
    logic [7:0]                    blue_reg;
    logic [7:0]                    green_reg;
    logic [7:0]                    red_reg;
    logic [mep_pkg::PIX_W-1:0]     pix_reg;
    logic                          load;

    assign res_ready = !valid_reg || m_ready;
    assign load      = res_valid && res_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            count_reg <= res.count;
            blue_reg  <= mep_pkg::SCALE5_LUT[res.count[4:0]];
            green_reg <= mep_pkg::SCALE5_LUT[res.count[9:5]];
            red_reg   <= mep_pkg::SCALE5_LUT[res.count[14:10]];
            pix_reg   <= res.pixel_index;
        end
    end

    assign m_valid           = valid_reg;
    assign m_iteration_count = count_reg;
    assign m_blue            = blue_reg;
    assign m_green           = green_reg;
    assign m_red             = red_reg;
    assign m_pixel_index     = pix_reg;

endmodule

`default_nettype wire

// ===== hdl/mandelbrot_escape_pixel.sv =====
// Top level of the escape-time pixel evaluator.
//
// Channel   Direction  Handshake           Payload
// s_        in         s_valid / s_ready   s_column, s_row
// m_        out        m_valid / m_ready   m_iteration_count, m_blue, m_green, m_red,
//                                          m_pixel_index
// cfg_      in         cfg_wr_en           cfg_index, cfg_wdata
//
// Each item passes MAP_CR, MAP_CI, MAP_PIX and MAP_END, then NEXT, SQR, SQI and TEST per
// iteration tried, ending in NEXT when a part of the new point leaves the bound. The
// shared 32 by 32 multiplier forms three products per iteration. Reset is synchronous
// and active low and returns the state, the valid flag and the configuration registers
// to their defaults. The input side accepts a new item while the previous result waits
// in the output register; a stalled result holds the sequencer in its final state.
`default_nettype none

module mandelbrot_escape_pixel (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [mep_pkg::COL_W-1:0]       s_column,
    input  wire logic [mep_pkg::ROW_W-1:0]       s_row,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [mep_pkg::COUNT_W-1:0]          m_iteration_count,
    output logic [7:0]                           m_blue,
    output logic [7:0]                           m_green,
    output logic [7:0]                           m_red,
    output logic [mep_pkg::PIX_W-1:0]            m_pixel_index,
    input  wire logic                            cfg_wr_en,
    input  wire logic [mep_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [31:0]                     cfg_wdata
);

    mep_pkg::cfg_t                      cfg;
    mep_pkg::result_t                   res;
    logic                               res_valid;
    logic                               res_ready;
    logic signed [mep_pkg::Q_W-1:0]     mul_a;
    logic signed [mep_pkg::Q_W-1:0]     mul_b;
    logic signed [mep_pkg::PROD_W-1:0]  prod;

    mep_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mep_mul u_mul (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod)
    );

    mep_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_column (s_column),
        .in_row    (s_row),
        .mul_a     (mul_a),
        .mul_b     (mul_b),
        .prod      (prod),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    mep_out_stage u_out (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .res_valid         (res_valid),
        .res_ready         (res_ready),
        .res               (res),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_iteration_count (m_iteration_count),
        .m_blue            (m_blue),
        .m_green           (m_green),
        .m_red             (m_red),
        .m_pixel_index     (m_pixel_index)
    );

endmodule

`default_nettype wire

// ===== hdl/mep_checker.sv =====
// Port-level assertions for the escape-time pixel block and their binding.
`default_nettype none

`include "mandelbrot_escape_pixel_macros.svh"

module mep_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_valid,
    input wire logic                           s_ready,
    input wire logic                           m_valid,
    input wire logic                           m_ready,
    input wire logic [mep_pkg::COUNT_W-1:0]    m_iteration_count,
    input wire logic [7:0]                     m_blue,
    input wire logic [7:0]                     m_red
);

    `MEP_ASSERT(a_result_held, m_valid && !m_ready |=> m_valid && $stable(m_iteration_count), "result item dropped or changed while stalled")
    `MEP_ASSERT(a_busy_after_accept, s_valid && s_ready |=> !s_ready, "input accepted again while an item is in work")
    `MEP_ASSERT(a_blue_zero, m_valid |-> ((m_iteration_count[4:0] == 5'd0) == (m_blue == 8'd0)), "blue channel does not follow the count")
    `MEP_ASSERT(a_red_full, m_valid |-> ((m_iteration_count[14:10] == 5'd31) == (m_red == 8'd255)), "red channel does not follow the count")

endmodule

bind mandelbrot_escape_pixel mep_checker u_mep_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_iteration_count (m_iteration_count),
    .m_blue            (m_blue),
    .m_red             (m_red)
);

`default_nettype wire
